// File: design/ipf_pkg.sv
// shared types and constants for the integer power unit
`default_nettype none
package ipf_pkg;

  localparam int EXP_W = 64;
  localparam logic [63:0] EXP_MASK = (EXP_W >= 64) ? {64{1'b1}}
                                   : ((64'd1 << (EXP_W % 64)) - 64'd1);
  localparam logic [63:0] ONE_BITS = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

  typedef enum logic [0:0] {
    OP_MUL,
    OP_RECIP
  } fpu_op_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SCAN,
    C_NEXT,
    C_SQW,
    C_MB,
    C_MBW,
    C_RCW,
    C_OUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_DNRM,
    F_DIV,
    F_NORM,
    F_DNM,
    F_RND,
    F_DONE
  } fpu_state_t;

  typedef struct packed {
    logic    load;
    logic    shift;
    logic    start;
    fpu_op_t op;
    logic    use_base;
    logic    v_wr;
    logic    v_one;
  } ipf_cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic top;
    logic cnt_zero;
    logic neg;
    logic done;
  } ipf_stat_t;

endpackage
`default_nettype wire

// File: design/ipf_fpu.sv
// multi-cycle binary64 multiply and reciprocal unit, round to nearest even
`default_nettype none
module ipf_fpu (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire ipf_pkg::fpu_op_t op,
  input  wire logic [63:0]      a,
  input  wire logic [63:0]      b,
  output logic                  done,
  output logic [63:0]           res
);

  ipf_pkg::fpu_state_t st_r, st_nxt;
  logic                sign_r, sign_nxt;
  logic signed [13:0]  er_r, er_nxt;
  logic [105:0]        p_r, p_nxt;
  logic [52:0]         ma_r, ma_nxt;
  logic [52:0]         mb_r, mb_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [53:0]         rem_r, rem_nxt;
  logic [63:0]         res_r, res_nxt;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [10:0] ea_eff, eb_eff;
  logic        spec_hit;
  logic [63:0] spec_res;

  always_comb begin
    a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    a_inf  = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
    b_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    a_zero = (a[62:0] == 63'd0);
    b_zero = (b[62:0] == 63'd0);
    ea_eff = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
    eb_eff = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
    spec_hit = 1'b1;
    spec_res = 64'd0;
    if (op == ipf_pkg::OP_MUL) begin
      if (a_nan) begin
        spec_res = {a[63], 12'hFFF, a[50:0]};
      end else if (b_nan) begin
        spec_res = {b[63], 12'hFFF, b[50:0]};
      end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
        spec_res = ipf_pkg::DEFAULT_NAN;
      end else if (a_inf || b_inf) begin
        spec_res = {a[63] ^ b[63], 11'h7FF, 52'd0};
      end else if (a_zero || b_zero) begin
        spec_res = {a[63] ^ b[63], 63'd0};
      end else begin
        spec_hit = 1'b0;
      end
    end else begin
      if (a_nan) begin
        spec_res = {a[63], 12'hFFF, a[50:0]};
      end else if (a_inf) begin
        spec_res = {a[63], 63'd0};
      end else if (a_zero) begin
        spec_res = {a[63], 11'h7FF, 52'd0};
      end else begin
        spec_hit = 1'b0;
      end
    end
  end

  // rounding of the normalized significand
  logic [52:0]        rm;
  logic               rinc;
  logic [53:0]        rsum;
  logic [52:0]        rmf;
  logic signed [13:0] re;

  always_comb begin
    rm   = p_r[105:53];
    rinc = p_r[52] & ((|p_r[51:0]) | rm[0]);
    rsum = {1'b0, rm} + {53'd0, rinc};
    if (rsum[53]) begin
      rmf = rsum[53:1];
      re  = er_r + 14'sd1;
    end else begin
      rmf = rsum[52:0];
      re  = er_r;
    end
  end

  // iterative multiply and divide steps
  logic [63:0]  mb_pad;
  logic [15:0]  chunk;
  logic [68:0]  pprod;
  logic [105:0] pshift;
  logic         q_ge;
  logic [53:0]  rem_sub;
  logic [55:0]  q_all;

  always_comb begin
    mb_pad = {11'd0, mb_r};
    chunk  = mb_pad[16 * cnt_r[1:0] +: 16];
    pprod  = ma_r * chunk;
    case (cnt_r[1:0])
      2'd0:    pshift = {37'd0, pprod};
      2'd1:    pshift = {21'd0, pprod, 16'd0};
      2'd2:    pshift = {5'd0, pprod, 32'd0};
      default: pshift = {pprod[57:0], 48'd0};
    endcase
    q_ge    = rem_r >= {1'b0, mb_r};
    rem_sub = q_ge ? (rem_r - {1'b0, mb_r}) : rem_r;
    q_all   = {p_r[54:0], q_ge};
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ipf_pkg::F_IDLE: begin
        if (start) begin
          if (spec_hit) begin
            st_nxt = ipf_pkg::F_DONE;
          end else if (op == ipf_pkg::OP_MUL) begin
            st_nxt = ipf_pkg::F_MUL;
          end else begin
            st_nxt = ipf_pkg::F_DNRM;
          end
        end
      end
      ipf_pkg::F_MUL:  if (cnt_r[1:0] == 2'd3) st_nxt = ipf_pkg::F_NORM;
      ipf_pkg::F_DNRM: if (mb_r[52]) st_nxt = ipf_pkg::F_DIV;
      ipf_pkg::F_DIV:  if (cnt_r == 6'd55) st_nxt = ipf_pkg::F_NORM;
      ipf_pkg::F_NORM: if (p_r[105] || (er_r <= 14'sd1)) st_nxt = ipf_pkg::F_DNM;
      ipf_pkg::F_DNM:  if (er_r >= 14'sd1) st_nxt = ipf_pkg::F_RND;
      ipf_pkg::F_RND:  st_nxt = ipf_pkg::F_DONE;
      ipf_pkg::F_DONE: st_nxt = ipf_pkg::F_IDLE;
      default:         st_nxt = ipf_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    sign_nxt = sign_r;
    er_nxt   = er_r;
    p_nxt    = p_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    case (st_r)
      ipf_pkg::F_IDLE: begin
        cnt_nxt = 6'd0;
        p_nxt   = 106'd0;
        if (op == ipf_pkg::OP_MUL) begin
          sign_nxt = a[63] ^ b[63];
          ma_nxt   = {a[62:52] != 11'd0, a[51:0]};
          mb_nxt   = {b[62:52] != 11'd0, b[51:0]};
          er_nxt   = 14'(ea_eff) + 14'(eb_eff) - 14'sd1022;
        end else begin
          sign_nxt = a[63];
          mb_nxt   = {a[62:52] != 11'd0, a[51:0]};
          er_nxt   = 14'sd2046 - 14'(ea_eff);
        end
        res_nxt = spec_res;
      end
      ipf_pkg::F_MUL: begin
        p_nxt   = p_r + pshift;
        cnt_nxt = cnt_r + 6'd1;
      end
      ipf_pkg::F_DNRM: begin
        if (mb_r[52]) begin
          rem_nxt = 54'd1 << 52;
          cnt_nxt = 6'd0;
        end else if (mb_r[52:45] == 8'd0) begin
          mb_nxt = {mb_r[44:0], 8'd0};
          er_nxt = er_r + 14'sd8;
        end else begin
          mb_nxt = {mb_r[51:0], 1'b0};
          er_nxt = er_r + 14'sd1;
        end
      end
      ipf_pkg::F_DIV: begin
        rem_nxt = {rem_sub[52:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd55) begin
          p_nxt = {q_all, rem_sub != 54'd0, 49'd0};
        end else begin
          p_nxt = {p_r[104:0], q_ge};
        end
      end
      ipf_pkg::F_NORM: begin
        if (!p_r[105] && (er_r > 14'sd1)) begin
          if ((p_r[105:98] == 8'd0) && (er_r > 14'sd8)) begin
            p_nxt  = {p_r[97:0], 8'd0};
            er_nxt = er_r - 14'sd8;
          end else begin
            p_nxt  = {p_r[104:0], 1'b0};
            er_nxt = er_r - 14'sd1;
          end
        end
      end
      ipf_pkg::F_DNM: begin
        if (er_r < -14'sd120) begin
          p_nxt  = {105'd0, |p_r};
          er_nxt = 14'sd1;
        end else if (er_r < -14'sd7) begin
          p_nxt  = {8'd0, p_r[105:9], |p_r[8:0]};
          er_nxt = er_r + 14'sd8;
        end else if (er_r < 14'sd1) begin
          p_nxt  = {1'b0, p_r[105:2], |p_r[1:0]};
          er_nxt = er_r + 14'sd1;
        end
      end
      ipf_pkg::F_RND: begin
        if (re >= 14'sd2047) begin
          res_nxt = {sign_r, 11'h7FF, 52'd0};
        end else begin
          res_nxt = {sign_r, rmf[52] ? re[10:0] : 11'd0, rmf[51:0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ipf_pkg::F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    sign_r <= sign_nxt;
    er_r   <= er_nxt;
    p_r    <= p_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  assign done = (st_r == ipf_pkg::F_DONE);
  assign res  = res_r;

endmodule
`default_nettype wire

// File: design/ipf_dp.sv
// datapath: operand and value registers, exponent scan register, shared fp unit
`default_nettype none
module ipf_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ipf_pkg::ipf_cmd_t cmd,
  input  wire logic [63:0]       in_base_bits,
  input  wire logic signed [63:0] in_exponent,
  output ipf_pkg::ipf_stat_t     stat,
  output logic [63:0]            value
);

  logic [63:0] base_r, base_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;

  logic [63:0] raw;
  logic        raw_neg;
  logic        fpu_done;
  logic [63:0] fpu_res;

  ipf_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .op    (cmd.op),
    .a     (v_r),
    .b     (cmd.use_base ? base_r : v_r),
    .done  (fpu_done),
    .res   (fpu_res)
  );

  always_comb begin
    raw      = in_exponent & ipf_pkg::EXP_MASK;
    raw_neg  = raw[ipf_pkg::EXP_W - 1];
    base_nxt = base_r;
    v_nxt    = v_r;
    mag_nxt  = mag_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    if (cmd.load) begin
      base_nxt = in_base_bits;
      v_nxt    = in_base_bits;
      neg_nxt  = raw_neg;
      mag_nxt  = raw_neg ? ((~raw + 64'd1) & ipf_pkg::EXP_MASK) : raw;
      cnt_nxt  = 7'd64;
    end
    if (cmd.shift) begin
      mag_nxt = {mag_r[62:0], 1'b0};
      cnt_nxt = cnt_r - 7'd1;
    end
    if (cmd.v_wr) begin
      v_nxt = fpu_res;
    end
    if (cmd.v_one) begin
      v_nxt = ipf_pkg::ONE_BITS;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    v_r    <= v_nxt;
    mag_r  <= mag_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
  end

  assign stat.mag_zero = (mag_r == 64'd0);
  assign stat.top      = mag_r[63];
  assign stat.cnt_zero = (cnt_r == 7'd0);
  assign stat.neg      = neg_r;
  assign stat.done     = fpu_done;
  assign value         = v_r;

endmodule
`default_nettype wire

// File: design/ipf_ctrl.sv
// controller: walks the exponent bits and sequences squares, multiplies, reciprocal
`default_nettype none
module ipf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire ipf_pkg::ipf_stat_t stat,
  output ipf_pkg::ipf_cmd_t       cmd,
  output logic                    busy,
  output logic                    out_valid
);

  ipf_pkg::ctrl_state_t st_r, st_nxt;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ipf_pkg::C_IDLE: if (start) st_nxt = ipf_pkg::C_SCAN;
      ipf_pkg::C_SCAN: begin
        if (stat.mag_zero) begin
          st_nxt = ipf_pkg::C_OUT;
        end else if (stat.top) begin
          st_nxt = ipf_pkg::C_NEXT;
        end
      end
      ipf_pkg::C_NEXT: begin
        if (!stat.cnt_zero) begin
          st_nxt = ipf_pkg::C_SQW;
        end else if (stat.neg) begin
          st_nxt = ipf_pkg::C_RCW;
        end else begin
          st_nxt = ipf_pkg::C_OUT;
        end
      end
      ipf_pkg::C_SQW: begin
        if (stat.done) begin
          st_nxt = stat.top ? ipf_pkg::C_MB : ipf_pkg::C_NEXT;
        end
      end
      ipf_pkg::C_MB:  st_nxt = ipf_pkg::C_MBW;
      ipf_pkg::C_MBW: if (stat.done) st_nxt = ipf_pkg::C_NEXT;
      ipf_pkg::C_RCW: if (stat.done) st_nxt = ipf_pkg::C_OUT;
      ipf_pkg::C_OUT: st_nxt = ipf_pkg::C_IDLE;
      default:        st_nxt = ipf_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{load: 1'b0, shift: 1'b0, start: 1'b0, op: ipf_pkg::OP_MUL,
            use_base: 1'b0, v_wr: 1'b0, v_one: 1'b0};
    case (st_r)
      ipf_pkg::C_IDLE: cmd.load = start;
      ipf_pkg::C_SCAN: begin
        // leading one is consumed here, the value already holds the base
        cmd.v_one = stat.mag_zero;
        cmd.shift = !stat.mag_zero;
      end
      ipf_pkg::C_NEXT: begin
        cmd.start = !stat.cnt_zero || stat.neg;
        cmd.op    = stat.cnt_zero ? ipf_pkg::OP_RECIP : ipf_pkg::OP_MUL;
      end
      ipf_pkg::C_SQW: begin
        cmd.v_wr  = stat.done;
        cmd.shift = stat.done && !stat.top;
      end
      ipf_pkg::C_MB: begin
        cmd.start    = 1'b1;
        cmd.use_base = 1'b1;
      end
      ipf_pkg::C_MBW: begin
        cmd.v_wr  = stat.done;
        cmd.shift = stat.done;
      end
      ipf_pkg::C_RCW: cmd.v_wr = stat.done;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ipf_pkg::C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign busy      = (st_r != ipf_pkg::C_IDLE);
  assign out_valid = (st_r == ipf_pkg::C_OUT);

endmodule
`default_nettype wire

// File: design/integer_power_float64.sv
// top level: binary64 base raised to a signed integer power
// An item is taken when start is high and busy is low; busy stays high until the result
// has been shown. The result appears on out_result_bits for exactly one cycle with
// out_valid high and cannot be held off. Time per item depends on the exponent and on the
// shared multi-cycle fp unit. After the accepting edge the exponent scan shifts out the
// leading zeros and the leading one. Each remaining exponent bit then costs one square, plus
// one multiply by the base when the bit is set. With normal operands and results each of these
// runs issue, 4 partial-product steps, 1 or 2 normalize, subnormal check, round, done.
// Subnormal operands or results add normalize and right shift steps. A negative exponent
// adds a reciprocal (56 divide steps), with more steps when the value or result is subnormal.
// A zero exponent goes from the scan straight to the result, which is then 1.0.
`default_nettype none
module integer_power_float64 (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [63:0]        in_base_bits,
  input  wire logic signed [63:0] in_exponent,
  output logic                    out_valid,
  output logic [63:0]             out_result_bits
);

  ipf_pkg::ipf_cmd_t  cmd;
  ipf_pkg::ipf_stat_t stat;

  ipf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ipf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_base_bits (in_base_bits),
    .in_exponent  (in_exponent),
    .stat         (stat),
    .value        (out_result_bits)
  );

endmodule
`default_nettype wire
